### design/sic_pkg.sv
// Package: op codes, status codes and shared types of the stack calculator.
package sic_pkg;

  localparam logic [3:0] OP_PUSH = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_SUB  = 4'd2;
  localparam logic [3:0] OP_MUL  = 4'd3;
  localparam logic [3:0] OP_DIV  = 4'd4;
  localparam logic [3:0] OP_REM  = 4'd5;
  localparam logic [3:0] OP_POW  = 4'd6;
  localparam logic [3:0] OP_SQRT = 4'd7;
  localparam logic [3:0] OP_POP  = 4'd8;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_OVER  = 3'd1;
  localparam logic [2:0] ST_UNDER = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_DOM   = 3'd4;

  typedef struct packed {
    logic        start;
    logic [3:0]  op;
    logic [31:0] s;
    logic [31:0] t;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic        ok;
    logic [2:0]  status;
    logic [31:0] r;
  } alu_rsp_t;

endpackage

### design/sic_alu.sv
// Multi-cycle arithmetic unit: wrap add/sub/mul, iterative div/rem, pow and sqrt.
module sic_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  sic_pkg::alu_req_t req,
  output sic_pkg::alu_rsp_t rsp
);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_DIV  = 3'd1;
  localparam logic [2:0] A_POW  = 3'd2;
  localparam logic [2:0] A_SQRT = 3'd3;
  localparam logic [2:0] A_DONE = 3'd4;
  localparam logic [2:0] A_POWM = 3'd5;

  logic [2:0]  st_r, st_nxt;
  logic [31:0] a_r, a_nxt;     // dividend/quotient, base, root value
  logic [31:0] b_r, b_nxt;     // divisor, exponent, root bit
  logic [32:0] rm_r, rm_nxt;   // remainder, accumulator, root result
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic        isdiv_r, isdiv_nxt;
  logic        ok_r, ok_nxt;
  logic [2:0]  stat_r, stat_nxt;
  logic [31:0] res_r, res_nxt;
  logic        done_r;
  logic [31:0] pm_acc, pm_base;
  logic [31:0] n, d, na, da;
  logic [32:0] sh, sub;

  assign rsp.done   = done_r;
  assign rsp.ok     = ok_r;
  assign rsp.status = stat_r;
  assign rsp.r      = res_r;

  always_comb begin
    pm_acc  = rm_r[31:0] * a_r;
    pm_base = a_r * a_r;
    n  = (req.op == sic_pkg::OP_DIV) ? req.s : req.t;
    d  = (req.op == sic_pkg::OP_DIV) ? req.t : req.s;
    na = n[31] ? (32'd0 - n) : n;
    da = d[31] ? (32'd0 - d) : d;
    sh  = {rm_r[31:0], a_r[31]};
    sub = sh - {1'b0, b_r};
  end

  always_comb begin
    st_nxt = st_r; a_nxt = a_r; b_nxt = b_r; rm_nxt = rm_r; cnt_nxt = cnt_r;
    neg_nxt = neg_r; isdiv_nxt = isdiv_r; ok_nxt = ok_r; stat_nxt = stat_r;
    res_nxt = res_r;
    unique case (st_r)
      A_IDLE: begin
        if (req.start) begin
          ok_nxt = 1'b1;
          stat_nxt = sic_pkg::ST_OK;
          st_nxt = A_DONE;
          unique case (req.op)
            sic_pkg::OP_ADD: res_nxt = req.s + req.t;
            sic_pkg::OP_SUB: res_nxt = req.s - req.t;
            sic_pkg::OP_MUL: begin
              a_nxt = req.s; rm_nxt = {1'b0, req.t}; st_nxt = A_POWM;
            end
            sic_pkg::OP_DIV, sic_pkg::OP_REM: begin
              if (d == 32'd0) begin
                ok_nxt = 1'b0; stat_nxt = sic_pkg::ST_DIVZ;
              end else begin
                a_nxt = na; b_nxt = da; rm_nxt = '0; cnt_nxt = 6'd32;
                isdiv_nxt = (req.op == sic_pkg::OP_DIV);
                neg_nxt = (req.op == sic_pkg::OP_DIV) ? (n[31] ^ d[31]) : n[31];
                st_nxt = A_DIV;
              end
            end
            sic_pkg::OP_POW: begin
              if (!req.t[31]) begin
                a_nxt = req.s; b_nxt = req.t; rm_nxt = 33'd1; st_nxt = A_POW;
              end else if (req.s == 32'd1) begin
                res_nxt = 32'd1;
              end else if (req.s == 32'hFFFF_FFFF) begin
                res_nxt = req.t[0] ? 32'hFFFF_FFFF : 32'd1;
              end else if (req.s == 32'd0) begin
                ok_nxt = 1'b0; stat_nxt = sic_pkg::ST_DOM;
              end else begin
                res_nxt = 32'd0;
              end
            end
            sic_pkg::OP_SQRT: begin
              if (req.t[31]) begin
                ok_nxt = 1'b0; stat_nxt = sic_pkg::ST_DOM;
              end else begin
                a_nxt = req.t; b_nxt = 32'h4000_0000; rm_nxt = '0; st_nxt = A_SQRT;
              end
            end
            default: begin
              ok_nxt = 1'b0; stat_nxt = sic_pkg::ST_DOM;
            end
          endcase
        end
      end
      A_POWM: begin
        res_nxt = pm_acc[31:0];
        st_nxt = A_DONE;
      end
      A_DIV: begin
        if (!sub[32]) begin
          rm_nxt = sub;
          a_nxt = {a_r[30:0], 1'b1};
        end else begin
          rm_nxt = sh;
          a_nxt = {a_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          st_nxt = A_DONE;
          if (isdiv_r) begin
            res_nxt = neg_r ? (32'd0 - a_nxt) : a_nxt;
          end else begin
            res_nxt = neg_r ? (32'd0 - rm_nxt[31:0]) : rm_nxt[31:0];
          end
        end
      end
      A_POW: begin
        if (b_r == 32'd0) begin
          res_nxt = rm_r[31:0];
          st_nxt = A_DONE;
        end else begin
          if (b_r[0]) rm_nxt = {1'b0, pm_acc[31:0]};
          a_nxt = pm_base[31:0];
          b_nxt = b_r >> 1;
        end
      end
      A_SQRT: begin
        if (b_r == 32'd0) begin
          res_nxt = rm_r[31:0];
          st_nxt = A_DONE;
        end else begin
          if ({1'b0, a_r} >= rm_r + {1'b0, b_r}) begin
            a_nxt = a_r - (rm_r[31:0] + b_r);
            rm_nxt = (rm_r >> 1) + {1'b0, b_r};
          end else begin
            rm_nxt = rm_r >> 1;
          end
          b_nxt = b_r >> 2;
        end
      end
      A_DONE: st_nxt = A_IDLE;
      default: st_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done_r <= (st_nxt == A_DONE);
    end
    a_r <= a_nxt; b_r <= b_nxt; rm_r <= rm_nxt; cnt_r <= cnt_nxt;
    neg_r <= neg_nxt; isdiv_r <= isdiv_nxt; ok_r <= ok_nxt; stat_r <= stat_nxt;
    res_r <= res_nxt;
  end

endmodule

### design/stack_integer_calculator.sv
// Top level: stack memory, sequencer and result register of the stack calculator.
// One instruction at a time. Add, sub and mul pass through the shared unit; div and rem
// run it for 32 restoring steps, pow squares once per exponent bit, and sqrt takes
// 16 steps. The top two stack words are read from a synchronous memory with one read
// and one write port, one word per cycle.
// The result beat is held in an output register; the next instruction is taken once
// that beat has been delivered. No clearing pass is needed after reset.
module stack_integer_calculator #(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [3:0] op, [35:4] push_value, [39:36] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [31:0] top_value, [40:32] stack_depth,
                                  // [43:41] status, [47:44] zero
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDT  = 3'd1;
  localparam logic [2:0] S_RDS  = 3'd2;
  localparam logic [2:0] S_GO   = 3'd3;
  localparam logic [2:0] S_ALU  = 3'd4;
  localparam logic [2:0] S_RDN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_r;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata;

  logic [2:0]  st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [3:0]  op_r;
  logic [31:0] pv_r, t_r, s_r;
  logic        ovalid_r, ovalid_nxt;
  logic [31:0] otop_r, otop_nxt;
  logic [2:0]  ostat_r, ostat_nxt;
  logic        otop_mem_r, otop_mem_nxt;
  logic        pend_r, pend_nxt;
  sic_pkg::alu_req_t req;
  sic_pkg::alu_rsp_t rsp;
  logic [31:0] top_out;

  sic_alu u_alu (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  assign in_tready = (st_r == S_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign top_out = otop_mem_r ? rd_r : otop_r;
  assign out_tdata = {4'd0, ostat_r, 9'(cnt_r), top_out};

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; ovalid_nxt = ovalid_r; otop_nxt = otop_r;
    ostat_nxt = ostat_r; otop_mem_nxt = otop_mem_r; pend_nxt = pend_r;
    we = 1'b0; waddr = AW'(cnt_r); wdata = pv_r;
    raddr = AW'(cnt_r - CW'(1));
    req.start = 1'b0; req.op = op_r; req.s = s_r; req.t = t_r;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: if (in_tvalid && in_tready) st_nxt = S_RDT;
      S_RDT: begin
        ostat_nxt = sic_pkg::ST_OK;
        st_nxt = S_OUT;
        unique case (op_r)
          sic_pkg::OP_PUSH: begin
            if (cnt_r >= CW'(DEPTH)) begin
              ostat_nxt = sic_pkg::ST_OVER; st_nxt = S_RDN;
            end else begin
              we = 1'b1; wdata = pv_r; waddr = AW'(cnt_r);
              cnt_nxt = cnt_r + CW'(1);
              otop_nxt = pv_r; otop_mem_nxt = 1'b0;
            end
          end
          sic_pkg::OP_ADD, sic_pkg::OP_SUB, sic_pkg::OP_MUL, sic_pkg::OP_DIV,
          sic_pkg::OP_REM, sic_pkg::OP_POW: begin
            if (cnt_r < CW'(2)) begin
              ostat_nxt = sic_pkg::ST_UNDER; st_nxt = S_RDN;
            end else begin
              raddr = AW'(cnt_r - CW'(2)); st_nxt = S_RDS;
            end
          end
          sic_pkg::OP_SQRT: begin
            if (cnt_r == '0) begin
              ostat_nxt = sic_pkg::ST_UNDER; st_nxt = S_RDN;
            end else begin
              st_nxt = S_GO;
            end
          end
          sic_pkg::OP_POP: begin
            if (cnt_r == '0) begin
              ostat_nxt = sic_pkg::ST_UNDER; st_nxt = S_RDN;
            end else begin
              cnt_nxt = cnt_r - CW'(1);
              otop_mem_nxt = 1'b1; pend_nxt = 1'b1; st_nxt = S_OUT;
            end
          end
          default: begin
            ostat_nxt = sic_pkg::ST_DOM; st_nxt = S_RDN;
          end
        endcase
      end
      S_RDS: st_nxt = S_GO;
      S_GO: begin
        req.start = 1'b1;
        st_nxt = S_ALU;
      end
      S_ALU: begin
        if (rsp.done) begin
          ostat_nxt = rsp.status;
          if (rsp.ok) begin
            if (op_r == sic_pkg::OP_SQRT) begin
              waddr = AW'(cnt_r - CW'(1));
            end else begin
              waddr = AW'(cnt_r - CW'(2));
              cnt_nxt = cnt_r - CW'(1);
            end
            we = 1'b1; wdata = rsp.r;
            otop_nxt = rsp.r; otop_mem_nxt = 1'b0;
            st_nxt = S_OUT;
          end else begin
            st_nxt = S_RDN;
          end
        end
      end
      S_RDN: begin
        // unchanged stack: show current top
        if (cnt_r == '0) begin
          otop_nxt = 32'd0; otop_mem_nxt = 1'b0;
        end else begin
          otop_mem_nxt = 1'b1; pend_nxt = 1'b1;
        end
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (pend_r) begin
          otop_nxt = rd_r; pend_nxt = 1'b0;
        end
        otop_mem_nxt = 1'b0;
        ovalid_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      ovalid_r <= 1'b0;
      otop_mem_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
      otop_mem_r <= otop_mem_nxt;
      pend_r <= pend_nxt;
    end
    otop_r <= otop_nxt;
    ostat_r <= ostat_nxt;
    if (st_r == S_IDLE && in_tvalid && in_tready) begin
      op_r <= in_tdata[3:0];
      pv_r <= in_tdata[35:4];
    end
    if (st_r == S_RDT) t_r <= rd_r;
    if (st_r == S_GO || st_r == S_RDS) s_r <= (st_r == S_RDS) ? rd_r : s_r;
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("stack count beyond capacity");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("input taken while result pending");
  a_alu_start: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> st_r == S_ALU) else $error("unit started outside sequence");
`endif

endmodule

### verif/tb.sv
// Testbench for the stack calculator: random and directed instruction beats, scoreboard check.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 256;
  localparam int LIMIT = 4000000;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] value;
  } instr_t;

  typedef struct packed {
    logic [31:0] top;
    logic [8:0]  depth;
    logic [2:0]  status;
  } calc_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;

  stack_integer_calculator #(.DEPTH(DEPTH)) dut (.*);

  instr_t       pending_instrs[$];
  calc_result_t expected_results[$];
  logic [31:0]  calc_stack[DEPTH];
  int           calc_depth;
  int           send_idle_pct;
  int           recv_stall_pct;
  bit           hold_send;
  int           errors;
  int           cycles;

  function automatic logic [31:0] int_power(logic [31:0] b, logic [31:0] e);
    logic [31:0] acc;
    acc = 1;
    while (e != 0) begin
      if (e[0]) acc = acc * b;
      b = b * b;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic [31:0] int_root(logic [31:0] v);
    logic [31:0] r;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      logic [63:0] c;
      c = {32'd0, r | (32'd1 << b)};
      if (c * c <= {32'd0, v}) r = c[31:0];
    end
    return r;
  endfunction

  function automatic calc_result_t execute(instr_t it);
    calc_result_t res;
    logic [31:0] s, t, r, n, d, na, da;
    logic popped, ok;
    res.status = sic_pkg::ST_OK;
    res.top = 0;
    popped = 0;
    r = 0;
    case (it.op)
      sic_pkg::OP_PUSH: begin
        if (calc_depth >= DEPTH) res.status = sic_pkg::ST_OVER;
        else begin
          calc_stack[calc_depth] = it.value;
          calc_depth++;
        end
      end
      sic_pkg::OP_ADD, sic_pkg::OP_SUB, sic_pkg::OP_MUL, sic_pkg::OP_DIV,
      sic_pkg::OP_REM, sic_pkg::OP_POW: begin
        if (calc_depth < 2) res.status = sic_pkg::ST_UNDER;
        else begin
          t = calc_stack[calc_depth-1];
          s = calc_stack[calc_depth-2];
          ok = 1;
          case (it.op)
            sic_pkg::OP_ADD: r = s + t;
            sic_pkg::OP_SUB: r = s - t;
            sic_pkg::OP_MUL: r = s * t;
            sic_pkg::OP_DIV, sic_pkg::OP_REM: begin
              n = (it.op == sic_pkg::OP_DIV) ? s : t;
              d = (it.op == sic_pkg::OP_DIV) ? t : s;
              if (d == 0) begin
                res.status = sic_pkg::ST_DIVZ;
                ok = 0;
              end else begin
                na = n[31] ? -n : n;
                da = d[31] ? -d : d;
                if (it.op == sic_pkg::OP_DIV) begin
                  r = na / da;
                  if (n[31] != d[31]) r = -r;
                end else begin
                  r = na % da;
                  if (n[31]) r = -r;
                end
              end
            end
            default: begin
              if (!t[31]) r = int_power(s, t);
              else if (s == 1) r = 1;
              else if (s == 32'hFFFF_FFFF) r = t[0] ? 32'hFFFF_FFFF : 1;
              else if (s == 0) begin
                res.status = sic_pkg::ST_DOM;
                ok = 0;
              end else r = 0;
            end
          endcase
          if (ok) begin
            calc_depth--;
            calc_stack[calc_depth-1] = r;
          end
        end
      end
      sic_pkg::OP_SQRT: begin
        if (calc_depth < 1) res.status = sic_pkg::ST_UNDER;
        else if (calc_stack[calc_depth-1][31]) res.status = sic_pkg::ST_DOM;
        else calc_stack[calc_depth-1] = int_root(calc_stack[calc_depth-1]);
      end
      sic_pkg::OP_POP: begin
        if (calc_depth < 1) res.status = sic_pkg::ST_UNDER;
        else begin
          calc_depth--;
          res.top = calc_stack[calc_depth];
          popped = 1;
        end
      end
      default: res.status = sic_pkg::ST_DOM;
    endcase
    if (!popped && calc_depth >= 1) res.top = calc_stack[calc_depth-1];
    res.depth = calc_depth[8:0];
    return res;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return $urandom_range(0, 40) - 20;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_instr(logic [3:0] op, logic [31:0] v);
    instr_t it;
    it.op = op;
    it.value = v;
    pending_instrs.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_instrs.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_instrs.size() != 0 && !hold_send &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        instr_t it;
        it = pending_instrs.pop_front();
        expected_results.push_back(execute(it));
        in_tdata <= {4'd0, it.value, it.op};
        in_tvalid <= 1;
      end else begin
        in_tvalid <= 0;
        in_tdata <= 40'({$urandom, $urandom});
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        calc_result_t got, want;
        got.top = out_tdata[31:0];
        got.depth = out_tdata[40:32];
        got.status = out_tdata[43:41];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, out_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.top !== want.top)
            $display("%0t: top exp %h got %h", $time, want.top, got.top);
          if (got.depth !== want.depth)
            $display("%0t: depth exp %0d got %0d", $time, want.depth, got.depth);
          if (got.status !== want.status)
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          if (got !== want) errors++;
        end
      end
      out_tready <= $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  initial begin
    int ph;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    out_tready = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_send = 0;
    errors = 0;
    cycles = 0;
    calc_depth = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;

    // directed
    add_instr(sic_pkg::OP_POP, 0);
    add_instr(sic_pkg::OP_SQRT, 0);
    add_instr(sic_pkg::OP_PUSH, 32'h8000_0000);
    add_instr(sic_pkg::OP_ADD, 0);
    add_instr(sic_pkg::OP_PUSH, 32'hFFFF_FFFF);
    add_instr(sic_pkg::OP_DIV, 0);
    add_instr(sic_pkg::OP_PUSH, 32'hFFFF_FFFF);
    add_instr(sic_pkg::OP_PUSH, 32'h8000_0000);
    add_instr(sic_pkg::OP_REM, 0);
    add_instr(sic_pkg::OP_PUSH, 0);
    add_instr(sic_pkg::OP_DIV, 0);
    add_instr(sic_pkg::OP_REM, 0);
    add_instr(sic_pkg::OP_POW, 0);
    add_instr(sic_pkg::OP_PUSH, 32'hFFFF_FFFD);
    add_instr(sic_pkg::OP_POW, 0);
    add_instr(sic_pkg::OP_SQRT, 0);
    add_instr(sic_pkg::OP_PUSH, 32'h7FFF_FFFF);
    add_instr(sic_pkg::OP_SQRT, 0);
    add_instr(sic_pkg::OP_SUB, 0);
    add_instr(sic_pkg::OP_PUSH, 7);
    add_instr(sic_pkg::OP_MUL, 0);
    add_instr(4'd9, 32'h5A5A_5A5A);
    add_instr(4'd15, 32'hFFFF_FFFF);
    wait_drained();

    // fill to overflow, then drain
    for (int i = 0; i < DEPTH + 2; i++) add_instr(sic_pkg::OP_PUSH, $urandom);
    for (int i = 0; i < DEPTH + 2; i++) add_instr(sic_pkg::OP_POP, 0);

    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 63 : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? 63 : 0;
      if (ph == 3) begin
        send_idle_pct = 7;
        recv_stall_pct = 7;
      end
      for (int i = 0; i < 450; i++) begin
        int k;
        k = $urandom_range(0, 99);
        if (k < 40 || calc_depth < 2) add_instr(sic_pkg::OP_PUSH, rand_word());
        else if (k < 95)
          add_instr(4'($urandom_range(sic_pkg::OP_ADD, sic_pkg::OP_POP)), 0);
        else add_instr(4'($urandom_range(0, 15)), $urandom);
      end
      wait_drained();
      if (ph == 1) begin
        hold_send = 1;
        add_instr(sic_pkg::OP_POW, $urandom);
        repeat (60) @(posedge clk);
        hold_send = 0;
        wait_drained();
      end
    end

    repeat (100) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
